// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the condition holds, the consequence must hold in the same cycle.
`define ALLE_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("%m: check failed");

// When the condition holds, the consequence must hold in the next cycle.
`define ALLE_ASSERT_NXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- src/alle_pkg.sv -----
// Types and constants shared by the linked list engine modules.
package alle_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 4;
  localparam int ENTRY_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int RDATA_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FIRST = 3'd0,
    OP_ADD_AFTER = 3'd1,
    OP_ADD_LAST  = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_AFTER = 3'd4,
    OP_DEL_LAST  = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_READ_OUT  = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NONE_AFTER = 3'd3,
    ST_FREE_POS   = 3'd4
  } st_t;

  typedef enum logic [1:0] {
    CS_NONE = 2'd0,
    CS_HEAD = 2'd1,
    CS_POS  = 2'd2,
    CS_NEXT = 2'd3
  } cur_sel_t;

  typedef enum logic [2:0] {
    LW_NEW_HEAD = 3'd0,
    LW_NEW_RD   = 3'd1,
    LW_CUR_NEW  = 3'd2,
    LW_PRED_RD  = 3'd3,
    LW_POS_RD   = 3'd4
  } lw_sel_t;

  typedef enum logic [1:0] {
    HO_NONE = 2'd0,
    HO_SET  = 2'd1,
    HO_POP  = 2'd2
  } head_op_t;

  typedef enum logic [1:0] {
    RS_NONE = 2'd0,
    RS_ZERO = 2'd1,
    RS_NEWS = 2'd2,
    RS_CUR  = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     cap;
    cur_sel_t cur_sel;
    logic     pred_clr;
    logic     pred_ld;
    logic     scan_clr;
    logic     scan_inc;
    logic     news_ld;
    logic     pl_we;
    logic     lk_we;
    lw_sel_t  lk_wsel;
    head_op_t head_op;
    logic     take;
    logic     free;
    logic     clear_all;
    res_sel_t res_sel;
    logic     step_clr;
    logic     step_inc;
    logic     emit;
    logic     emit_read;
    logic     emit_last;
    st_t      emit_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic hv;
    logic pos_live;
    logic scan_used;
    logic rd_end;
    logic has_pred;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/array_linked_list_engine_top.sv -----
// The free-slot scan advances one slot per cycle, and each walk step waits for the
// registered read of the link memory. Read-out gives one result per element and
// waits while the output register is still full. One operation at a time; the
// next input is taken once the last result has entered the output register.
// Synchronous active-high reset empties the list at once.
module array_linked_list_engine_top #(
  parameter int SLOTS     = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [alle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // position[3:0],
                                                             // entry_data[35:4], zero
  input  logic [alle_pkg::OP_W-1:0]           s_axis_tuser,  // operation[2:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [alle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // slot[3:0], read_data[35:4],
                                                             // element_count[40:36], zero
  output logic [alle_pkg::STATUS_W-1:0]       m_axis_tuser,  // status[2:0]
  output logic                                m_axis_tlast
);
  import alle_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [RDATA_W-1:0]  out_data;
  logic [COUNT_W-1:0]  out_count;

  alle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  alle_dp #(.SLOTS(SLOTS), .DATA_BITS(DATA_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_axis_tuser),
    .in_pos(s_axis_tdata[3:0]), .in_data(s_axis_tdata[35:4]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(out_status), .out_slot(out_slot), .out_data(out_data),
    .out_count(out_count), .out_last(m_axis_tlast)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {7'd0, out_count, out_data, out_slot};

endmodule

// ----- src/alle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/alle_dp.sv -----
// Datapath: list state, link and payload memories, walk registers, result register.
module alle_dp #(
  parameter int SLOTS     = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  alle_pkg::cmd_t              cmd,
  output alle_pkg::sts_t              sts,
  input  logic [alle_pkg::OP_W-1:0]   in_op,
  input  logic [alle_pkg::POS_W-1:0]  in_pos,
  input  logic [alle_pkg::ENTRY_W-1:0] in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [alle_pkg::STATUS_W-1:0] out_status,
  output logic [alle_pkg::SLOT_W-1:0] out_slot,
  output logic [alle_pkg::RDATA_W-1:0] out_data,
  output logic [alle_pkg::COUNT_W-1:0] out_count,
  output logic                        out_last
);
  import alle_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [IW-1:0]        cur, pred, news, scan, step, res, head, pos_idx;
  logic                 has_pred, hv;
  logic [CW-1:0]        count;
  logic [SLOTS-1:0]     used;
  op_t                  op_q;
  logic [POS_W-1:0]     pos_q;
  logic [DATA_BITS-1:0] data_q;
  logic [IW:0]          lk_rd, lk_wdata;
  logic [IW-1:0]        lk_waddr;
  logic [DATA_BITS-1:0] pl_rd;
  logic [31:0]          pos32, slot32, cnt32;
  logic [63:0]          rd64;

  assign pos_idx = IW'(pos_q);
  assign pos32   = 32'(pos_q);

  alle_ram #(.WIDTH(IW + 1), .DEPTH(SLOTS)) u_links (
    .clk(clk), .we(cmd.lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(cur), .rdata(lk_rd)
  );

  alle_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_payloads (
    .clk(clk), .we(cmd.pl_we), .waddr(scan), .wdata(data_q),
    .raddr(cur), .rdata(pl_rd)
  );

  always_comb begin
    lk_waddr = news;
    lk_wdata = lk_rd;
    unique case (cmd.lk_wsel)
      LW_NEW_HEAD: begin
        lk_waddr = news;
        lk_wdata = {~hv, head};
      end
      LW_NEW_RD:  lk_waddr = news;
      LW_CUR_NEW: begin
        lk_waddr = cur;
        lk_wdata = {1'b0, news};
      end
      LW_PRED_RD: lk_waddr = pred;
      LW_POS_RD:  lk_waddr = pos_idx;
      default:    lk_waddr = news;
    endcase
  end

  assign sts.op        = op_q;
  assign sts.full      = (count >= CW'(SLOTS));
  assign sts.hv        = hv;
  assign sts.pos_live  = (pos32 < SLOTS) && used[pos_idx];
  assign sts.scan_used = used[scan];
  assign sts.rd_end    = lk_rd[IW];
  assign sts.has_pred  = has_pred;
  assign sts.step_last = (step == IW'(SLOTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  // List control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      used  <= '0;
      hv    <= 1'b0;
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.take) begin
        used[news] <= 1'b1;
        count      <= count + 1'b1;
      end else if (cmd.free) begin
        used[cur] <= 1'b0;
        if (count != '0) begin
          count <= count - 1'b1;
        end
      end
      case (cmd.head_op)
        HO_SET: begin
          head <= news;
          hv   <= 1'b1;
        end
        HO_POP: begin
          hv   <= ~lk_rd[IW];
          head <= lk_rd[IW] ? '0 : lk_rd[IW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Walk and capture registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q   <= op_t'(in_op);
      pos_q  <= in_pos;
      data_q <= DATA_BITS'(in_data);
    end
    case (cmd.cur_sel)
      CS_HEAD: cur <= head;
      CS_POS:  cur <= pos_idx;
      CS_NEXT: cur <= lk_rd[IW-1:0];
      default: ;
    endcase
    if (cmd.pred_clr) begin
      has_pred <= 1'b0;
    end else if (cmd.pred_ld) begin
      has_pred <= 1'b1;
      pred     <= cur;
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
    if (cmd.news_ld) begin
      news <= scan;
    end
    if (cmd.step_clr) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + 1'b1;
    end
    case (cmd.res_sel)
      RS_ZERO: res <= '0;
      RS_NEWS: res <= news;
      RS_CUR:  res <= cur;
      default: ;
    endcase
  end

  assign slot32 = cmd.emit_read ? 32'(cur) : 32'(res);
  assign cnt32  = 32'(count);
  assign rd64   = 64'(pl_rd);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_slot   <= slot32[SLOT_W-1:0];
      out_data   <= cmd.emit_read ? rd64[RDATA_W-1:0] : '0;
      out_count  <= cnt32[COUNT_W-1:0];
      out_last   <= cmd.emit_last;
    end
  end

endmodule

// ----- src/alle_ctrl.sv -----
// Controller: sequences each operation over the datapath.
module alle_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  alle_pkg::sts_t sts,
  output alle_pkg::cmd_t cmd
);
  import alle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SCAN, S_NF, S_INS, S_INS2, S_WAIT, S_WALK,
    S_DL, S_DF, S_DA1, S_DA2, S_RD, S_EMIT
  } state_t;

  state_t state, state_next, ret, ret_next;
  st_t    res_status, res_status_next;
  logic   fin;

  assign in_ready = (state == S_IDLE);
  assign fin      = sts.rd_end || sts.step_last;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    ret_next        = ret;
    res_status_next = res_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap         = 1'b1;
          cmd.res_sel     = RS_ZERO;
          res_status_next = ST_OK;
          state_next      = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST: begin
            if (sts.full) begin
              res_status_next = ST_FULL;
              state_next      = S_EMIT;
            end else if (sts.op == OP_ADD_AFTER && !sts.pos_live) begin
              res_status_next = ST_FREE_POS;
              state_next      = S_EMIT;
            end else begin
              cmd.scan_clr = 1'b1;
              cmd.pred_clr = 1'b1;
              cmd.cur_sel  = (sts.op == OP_ADD_AFTER) ? CS_POS : CS_HEAD;
              state_next   = S_SCAN;
            end
          end
          OP_DEL_FIRST, OP_DEL_LAST, OP_READ_OUT: begin
            if (!sts.hv) begin
              res_status_next = ST_EMPTY;
              state_next      = S_EMIT;
            end else begin
              cmd.cur_sel  = CS_HEAD;
              cmd.pred_clr = 1'b1;
              cmd.step_clr = 1'b1;
              state_next   = S_WAIT;
              ret_next     = (sts.op == OP_DEL_FIRST) ? S_DF :
                             (sts.op == OP_DEL_LAST)  ? S_WALK : S_RD;
            end
          end
          OP_DEL_AFTER: begin
            if (!sts.pos_live) begin
              res_status_next = ST_FREE_POS;
              state_next      = S_EMIT;
            end else begin
              cmd.cur_sel = CS_POS;
              state_next  = S_WAIT;
              ret_next    = S_DA1;
            end
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = S_EMIT;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        // Advance to the lowest free slot, then store the payload there.
        if (sts.scan_used) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.news_ld = 1'b1;
          cmd.pl_we   = 1'b1;
          if (sts.op == OP_ADD_FIRST || !sts.hv) begin
            state_next = S_NF;
          end else if (sts.op == OP_ADD_AFTER) begin
            state_next = S_INS;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_NF: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_wsel = LW_NEW_HEAD;
        cmd.head_op = HO_SET;
        cmd.take    = 1'b1;
        cmd.res_sel = RS_NEWS;
        state_next  = S_EMIT;
      end
      S_INS: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_wsel = LW_NEW_RD;
        state_next  = S_INS2;
      end
      S_INS2: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_wsel = LW_CUR_NEW;
        cmd.take    = 1'b1;
        cmd.res_sel = RS_NEWS;
        state_next  = S_EMIT;
      end
      S_WAIT: state_next = ret;
      S_WALK: begin
        if (sts.rd_end) begin
          state_next = (sts.op == OP_DEL_LAST) ? S_DL : S_INS;
        end else begin
          cmd.pred_ld = 1'b1;
          cmd.cur_sel = CS_NEXT;
          state_next  = S_WAIT;
          ret_next    = S_WALK;
        end
      end
      S_DL: begin
        if (sts.has_pred) begin
          cmd.lk_we   = 1'b1;
          cmd.lk_wsel = LW_PRED_RD;
        end else begin
          cmd.head_op = HO_POP;
        end
        cmd.free    = 1'b1;
        cmd.res_sel = RS_CUR;
        state_next  = S_EMIT;
      end
      S_DF: begin
        cmd.head_op = HO_POP;
        cmd.free    = 1'b1;
        cmd.res_sel = RS_CUR;
        state_next  = S_EMIT;
      end
      S_DA1: begin
        if (sts.rd_end) begin
          res_status_next = ST_NONE_AFTER;
          state_next      = S_EMIT;
        end else begin
          cmd.cur_sel = CS_NEXT;
          state_next  = S_WAIT;
          ret_next    = S_DA2;
        end
      end
      S_DA2: begin
        cmd.lk_we   = 1'b1;
        cmd.lk_wsel = LW_POS_RD;
        cmd.free    = 1'b1;
        cmd.res_sel = RS_CUR;
        state_next  = S_EMIT;
      end
      S_RD: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_read = 1'b1;
          cmd.emit_last = fin;
          if (fin) begin
            state_next = S_IDLE;
          end else begin
            cmd.cur_sel  = CS_NEXT;
            cmd.step_inc = 1'b1;
            state_next   = S_WAIT;
            ret_next     = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = res_status;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      res_status <= ST_OK;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      res_status <= res_status_next;
    end
  end

endmodule

// ----- src/alle_checker.sv -----
// Port-level checker for the linked list engine, bound to the top level.
`include "assert_macros.svh"

module alle_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import alle_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  `ALLE_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `ALLE_ASSERT_NXT(a_busy_after_take, clk, rst, in_xfer, !s_axis_tready)
  `ALLE_ASSERT_IMP(a_error_is_last, clk, rst, m_axis_tvalid && m_axis_tuser != ST_OK,
    m_axis_tlast && m_axis_tdata[35:4] == 32'd0)
  `ALLE_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid, m_axis_tuser <= ST_FREE_POS)

endmodule

bind array_linked_list_engine_top alle_port_checker u_alle_checker (.*);

// ----- bench/alle_checker.sv -----
// Result checker for the linked list engine: watches both streams and compares.
`timescale 1ns / 1ps
module alle_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [39:0] in_data,
  input  logic [2:0]  in_user,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [47:0] out_data,
  input  logic [2:0]  out_user,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import alle_pkg::*;

  typedef struct packed {
    st_t         status;
    logic [3:0]  slot;
    logic [31:0] rdata;
    logic [4:0]  cnt;
    logic        last;
  } result_t;

  result_t want_q[$];

  logic        used_m [16];
  logic        end_m  [16];
  logic [3:0]  nxt_m  [16];
  logic [31:0] pay_m  [16];
  logic        head_ok;
  logic [3:0]  head_m;
  logic [4:0]  cnt_m;

  assign pending = want_q.size();

  function automatic result_t mk(st_t st, logic [3:0] s, logic [31:0] d, logic l);
    result_t r;
    r.status = st; r.slot = s; r.rdata = d; r.cnt = cnt_m; r.last = l;
    return r;
  endfunction

  task automatic wipe_list();
    for (int i = 0; i < 16; i++) begin
      used_m[i] = 0; end_m[i] = 0; nxt_m[i] = 0;
    end
    head_ok = 0; head_m = 0; cnt_m = 0;
  endtask

  function automatic logic [3:0] grab_slot(logic [31:0] d);
    logic [3:0] s;
    s = 0;
    for (int i = 15; i >= 0; i--) if (!used_m[i]) s = i[3:0];
    used_m[s] = 1; pay_m[s] = d; cnt_m++;
    return s;
  endfunction

  task automatic release_slot(logic [3:0] s);
    used_m[s] = 0; end_m[s] = 0; nxt_m[s] = 0;
    if (cnt_m > 0) cnt_m--;
  endtask

  task automatic push_front(logic [31:0] d, output logic [3:0] s);
    s = grab_slot(d);
    end_m[s] = !head_ok; nxt_m[s] = head_m; head_m = s; head_ok = 1;
  endtask

  task automatic link_after(logic [3:0] p, logic [31:0] d, output logic [3:0] s);
    s = grab_slot(d);
    end_m[s] = end_m[p]; nxt_m[s] = nxt_m[p]; end_m[p] = 0; nxt_m[p] = s;
  endtask

  task automatic pop_front(output logic [3:0] s);
    s = head_m;
    head_ok = !end_m[s]; head_m = end_m[s] ? 4'd0 : nxt_m[s];
    release_slot(s);
  endtask

  task automatic unlink_after(logic [3:0] p, output logic [3:0] s);
    s = nxt_m[p];
    end_m[p] = end_m[s]; nxt_m[p] = nxt_m[s];
    release_slot(s);
  endtask

  task automatic walk_tail(output logic [3:0] t, output logic [3:0] pr,
                           output logic hp);
    int n;
    t = head_m; pr = 0; hp = 0; n = 0;
    while (!end_m[t] && n < 16) begin
      pr = t; hp = 1; t = nxt_m[t]; n++;
    end
  endtask

  task automatic predict_op(op_t op, logic [3:0] pos, logic [31:0] d);
    logic [3:0] s, t, pr;
    logic hp, full;
    full = cnt_m >= 16;
    case (op)
      OP_ADD_FIRST: begin
        if (full) want_q.push_back(mk(ST_FULL, 0, 0, 1));
        else begin push_front(d, s); want_q.push_back(mk(ST_OK, s, 0, 1)); end
      end
      OP_ADD_AFTER: begin
        if (full) want_q.push_back(mk(ST_FULL, 0, 0, 1));
        else if (!used_m[pos]) want_q.push_back(mk(ST_FREE_POS, 0, 0, 1));
        else begin link_after(pos, d, s); want_q.push_back(mk(ST_OK, s, 0, 1)); end
      end
      OP_ADD_LAST: begin
        if (full) want_q.push_back(mk(ST_FULL, 0, 0, 1));
        else begin
          if (!head_ok) push_front(d, s);
          else begin walk_tail(t, pr, hp); link_after(t, d, s); end
          want_q.push_back(mk(ST_OK, s, 0, 1));
        end
      end
      OP_DEL_FIRST: begin
        if (!head_ok) want_q.push_back(mk(ST_EMPTY, 0, 0, 1));
        else begin pop_front(s); want_q.push_back(mk(ST_OK, s, 0, 1)); end
      end
      OP_DEL_AFTER: begin
        if (!used_m[pos]) want_q.push_back(mk(ST_FREE_POS, 0, 0, 1));
        else if (end_m[pos]) want_q.push_back(mk(ST_NONE_AFTER, 0, 0, 1));
        else begin unlink_after(pos, s); want_q.push_back(mk(ST_OK, s, 0, 1)); end
      end
      OP_DEL_LAST: begin
        if (!head_ok) want_q.push_back(mk(ST_EMPTY, 0, 0, 1));
        else begin
          walk_tail(t, pr, hp);
          if (hp) unlink_after(pr, s); else pop_front(s);
          want_q.push_back(mk(ST_OK, s, 0, 1));
        end
      end
      OP_CLEAR: begin
        wipe_list();
        want_q.push_back(mk(ST_OK, 0, 0, 1));
      end
      default: begin
        if (!head_ok) want_q.push_back(mk(ST_EMPTY, 0, 0, 1));
        else begin
          s = head_m;
          for (int n = 0; n < 16; n++) begin
            hp = end_m[s] || n == 15;
            want_q.push_back(mk(ST_OK, s, pay_m[s], hp));
            if (hp) break;
            s = nxt_m[s];
          end
        end
      end
    endcase
  endtask

  result_t got, exp_r;

  always @(posedge clk) begin
    if (rst) begin
      wipe_list();
      want_q.delete();
      fail_count <= 0;
    end else begin
      // Check output before predicting: a result never comes in the input's cycle.
      if (out_valid && out_ready) begin
        got.status = st_t'(out_user);
        got.slot   = out_data[3:0];
        got.rdata  = out_data[35:4];
        got.cnt    = out_data[40:36];
        got.last   = out_last;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected st=%0d slot=%0d data=%h cnt=%0d last=%0b",
                     $time, exp_r.status, exp_r.slot, exp_r.rdata, exp_r.cnt,
                     exp_r.last);
            $display("%0t:          actual   st=%0d slot=%0d data=%h cnt=%0d last=%0b",
                     $time, got.status, got.slot, got.rdata, got.cnt, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_op(op_t'(in_user), in_data[3:0], in_data[35:4]);
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Stimulus and verdict for the linked list engine testbench.
`timescale 1ns / 1ps
module tb_top;
  import alle_pkg::*;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, pending;
  int          cycles;
  int          live_cnt;

  array_linked_list_engine_top dut (.*);

  alle_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_user(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver stall pattern; some stretches never stall.
  int stall_mode;
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1;
    else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1;
        1: m_axis_tready <= $urandom_range(0, 3) != 0;
        2: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  int burst_left;

  // Present one item and hold it until transferred; gaps between bursts.
  task automatic send_op(op_t op, logic [3:0] pos, logic [31:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'd0, d, pos};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    if (op inside {OP_ADD_FIRST, OP_ADD_AFTER, OP_ADD_LAST}) begin
      if (live_cnt < 16) live_cnt++;
    end else if (op == OP_CLEAR) live_cnt = 0;
    else if (op inside {OP_DEL_FIRST, OP_DEL_LAST} && live_cnt > 0) live_cnt--;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  int r;
  initial begin
    rst = 1; burst_left = 0; live_cnt = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty cases, free positions, fill to full, tail cases.
    send_op(OP_DEL_FIRST, 0, 0);
    send_op(OP_DEL_LAST, 0, 0);
    send_op(OP_READ_OUT, 0, 0);
    send_op(OP_DEL_AFTER, 15, 0);
    send_op(OP_ADD_AFTER, 3, 32'h1234);
    send_op(OP_ADD_LAST, 0, 32'hFFFF_FFFF);
    send_op(OP_DEL_AFTER, 0, 0);
    for (int i = 0; i < 16; i++)
      send_op(op_t'(i % 3), 4'(i), i[0] ? 32'hFFFF_FFFF : 32'h0);
    send_op(OP_ADD_AFTER, 15, 1);
    send_op(OP_READ_OUT, 0, 0);
    send_op(OP_DEL_LAST, 0, 0);
    send_op(OP_CLEAR, 0, 0);

    // Random: mostly adds while short, deletes while long, reads between.
    for (int n = 0; n < 390; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_op(OP_CLEAR, 4'($urandom), $urandom);
      else if (r < 15) send_op(OP_READ_OUT, 4'($urandom), $urandom);
      else if (r < 15 + 60 - 3 * live_cnt)
        send_op(op_t'($urandom_range(0, 2)), 4'($urandom), rnd_word());
      else send_op(op_t'($urandom_range(3, 5)), 4'($urandom), $urandom);
    end
    send_op(OP_READ_OUT, 0, 0);
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
